FILE: rtl/prf_pkg.sv
`timescale 1ns / 1ps
package prf_pkg;

  localparam int unsigned MaxFactorsDefault = 16;
  localparam int unsigned ModWidthDefault   = 32;

  // sequencer states
  typedef enum logic [4:0] {
    StIdle,
    StFacChk,      // test d*d <= cofactor
    StFacDiv,      // start cofactor / d
    StFacDivWait,
    StFacStore,    // d divides: record it
    StFacStrip,    // divide cofactor by d repeatedly
    StFacStripWait,
    StFacTail,
    StCandStart,
    StExpDiv,      // phi / p
    StExpDivWait,
    StPowInit,
    StPowMul,      // start a modular product
    StPowMulWait,
    StPowNext,
    StPowCheck,
    StCandNext,
    StOut
  } state_e;

  // command from the sequencer to the divider
  typedef struct packed {
    logic start;
    logic sel_prod; // 1: dividend is the 64-bit product, else zero-extended word
  } div_cmd_t;

endpackage

FILE: rtl/prf_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
module prf_divider import prf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o,
  output logic [31:0] rem_o
);

  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  assign trial = {rem_q, quot_q[63]} - {2'b00, div_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quot_q[63]};
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[31:0];

endmodule

FILE: rtl/primitive_root_finder_core.sv
`timescale 1ns / 1ps
// Smallest primitive root of a prime modulus.
// Input stream: s_axis_* carries one modulus per transfer. Output stream:
// m_axis_* carries one root per modulus (0 if none found or modulus < 2).
// The block factors phi = m-1 by trial division, then tests candidates
// 2, 3, ... by square-and-multiply exponentiation c^(phi/p) mod m.
// All divisions, remainders and modular products go through one shared
// restoring divider, one operation at a time; the time a modulus takes
// depends on its value, its factors and the number of candidates tried.
// One modulus is in work at a time; s_axis_tready is high only when the
// sequencer is idle and no result waits. The result sits in an output
// register until taken; a stalled receiver holds the block idle-waiting
// with the result stable.
// Reset clears the sequencer and output valid; the factor store holds
// nothing meaningful until a modulus writes it.
module primitive_root_finder_core import prf_pkg::*; #(
  parameter int unsigned MAX_FACTORS = MaxFactorsDefault,
  parameter int unsigned MOD_WIDTH   = ModWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] modulus
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] root
);

  localparam int unsigned IdxW = $clog2(MAX_FACTORS);
  localparam int unsigned CntW = $clog2(MAX_FACTORS + 1);

  state_e state_q, state_d;

  logic [31:0] fstore_q [MAX_FACTORS];
  logic [CntW-1:0] fcnt_q, fcnt_d;
  logic [31:0] m_q, m_d, phi_q, phi_d, cof_q, cof_d;
  logic [32:0] d_q, d_d, cand_q, cand_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [31:0] exp_q, exp_d, acc_q, acc_d, b_q, b_d;
  logic        mulsq_q, mulsq_d; // 0: acc*b, 1: b*b
  logic        fail_q, fail_d;
  logic [31:0] res_q, res_d;
  logic        ovld_q, ovld_d;
  logic        wr_en;
  logic [31:0] wr_data;

  // shared divider
  logic        div_start, div_busy;
  logic [63:0] div_dvd, div_quot;
  logic [31:0] div_dvs, div_rem;
  logic [63:0] prod;

  prf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign prod = mulsq_q ? (64'(b_q) * 64'(b_q)) : (64'(acc_q) * 64'(b_q));
  logic [31:0] p_cur;
  assign p_cur = fstore_q[k_q];
  logic [65:0] dsq;
  assign dsq = 66'(d_q) * 66'(d_q);

  // next state and datapath control
  always_comb begin
    state_d = state_q;
    fcnt_d = fcnt_q; m_d = m_q; phi_d = phi_q; cof_d = cof_q;
    d_d = d_q; cand_d = cand_q; k_d = k_q; exp_d = exp_q;
    acc_d = acc_q; b_d = b_q; mulsq_d = mulsq_q; fail_d = fail_q;
    res_d = res_q; ovld_d = ovld_q;
    div_start = 1'b0; div_dvd = '0; div_dvs = '0;
    wr_en = 1'b0; wr_data = '0;
    if (m_axis_tready) ovld_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && !ovld_q) begin
          m_d = 32'(s_axis_tdata[MOD_WIDTH-1:0]);
          fcnt_d = '0;
          if (32'(s_axis_tdata[MOD_WIDTH-1:0]) < 32'd2) begin
            res_d = '0;
            state_d = StOut;
          end else begin
            phi_d = 32'(s_axis_tdata[MOD_WIDTH-1:0]) - 32'd1;
            cof_d = 32'(s_axis_tdata[MOD_WIDTH-1:0]) - 32'd1;
            d_d = 33'd2;
            state_d = StFacChk;
          end
        end
      end
      StFacChk: begin
        if (dsq <= 66'(cof_q)) state_d = StFacDiv;
        else state_d = StFacTail;
      end
      StFacDiv: begin
        div_start = 1'b1; div_dvd = 64'(cof_q); div_dvs = d_q[31:0];
        state_d = StFacDivWait;
      end
      StFacDivWait: begin
        if (!div_busy) begin
          if (div_rem == '0) state_d = StFacStore;
          else begin
            d_d = d_q + 33'd1;
            state_d = StFacChk;
          end
        end
      end
      StFacStore: begin
        if (32'(fcnt_q) < 32'(MAX_FACTORS)) begin
          wr_en = 1'b1; wr_data = d_q[31:0];
          fcnt_d = fcnt_q + CntW'(1);
        end
        state_d = StFacStrip;
      end
      StFacStrip: begin
        div_start = 1'b1; div_dvd = 64'(cof_q); div_dvs = d_q[31:0];
        state_d = StFacStripWait;
      end
      StFacStripWait: begin
        if (!div_busy) begin
          if (div_rem == '0) begin
            cof_d = div_quot[31:0];
            state_d = StFacStrip;
          end else begin
            d_d = d_q + 33'd1;
            state_d = StFacChk;
          end
        end
      end
      StFacTail: begin
        if (cof_q > 32'd1 && 32'(fcnt_q) < 32'(MAX_FACTORS)) begin
          wr_en = 1'b1; wr_data = cof_q;
          fcnt_d = fcnt_q + CntW'(1);
        end
        cand_d = 33'd2;
        state_d = StCandStart;
      end
      StCandStart: begin
        if (cand_q > 33'(m_q)) begin
          res_d = '0;
          state_d = StOut;
        end else begin
          k_d = '0;
          fail_d = 1'b0;
          state_d = StPowCheck;
        end
      end
      StPowCheck: begin
        // next factor, or verdict for this candidate
        if (fail_q) state_d = StCandNext;
        else if (32'(k_q) >= 32'(fcnt_q)) begin
          res_d = cand_q[31:0];
          state_d = StOut;
        end else if (p_cur == '0) begin
          k_d = k_q + IdxW'(1);
        end else state_d = StExpDiv;
      end
      StExpDiv: begin
        div_start = 1'b1; div_dvd = 64'(phi_q); div_dvs = p_cur;
        state_d = StExpDivWait;
      end
      StExpDivWait: begin
        if (!div_busy) begin
          exp_d = div_quot[31:0];
          state_d = StPowInit;
        end
      end
      StPowInit: begin
        // b = c mod m (cand <= m), acc = 1 (m >= 2)
        acc_d = 32'd1;
        b_d = (cand_q == 33'(m_q)) ? 32'd0 : cand_q[31:0];
        state_d = StPowNext;
      end
      StPowNext: begin
        if (exp_q == '0) begin
          if (acc_q == 32'd1) fail_d = 1'b1;
          k_d = k_q + IdxW'(1);
          state_d = StPowCheck;
        end else begin
          mulsq_d = ~exp_q[0];
          state_d = StPowMul;
        end
      end
      StPowMul: begin
        div_start = 1'b1; div_dvd = prod; div_dvs = m_q;
        state_d = StPowMulWait;
      end
      StPowMulWait: begin
        if (!div_busy) begin
          if (!mulsq_q) begin
            acc_d = div_rem;
            mulsq_d = 1'b1;
            state_d = StPowMul;
          end else begin
            b_d = div_rem;
            exp_d = exp_q >> 1;
            state_d = StPowNext;
          end
        end
      end
      StCandNext: begin
        cand_d = cand_q + 33'd1;
        state_d = StCandStart;
      end
      StOut: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
      fcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      fcnt_q  <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; phi_q <= phi_d; cof_q <= cof_d; d_q <= d_d;
    cand_q <= cand_d; k_q <= k_d; exp_q <= exp_d; acc_q <= acc_d;
    b_q <= b_d; mulsq_q <= mulsq_d; fail_q <= fail_d; res_q <= res_d;
  end

  // factor store
  always_ff @(posedge clk_i) begin
    if (wr_en) fstore_q[fcnt_q[IdxW-1:0]] <= wr_data;
  end

  assign s_axis_tready = (state_q == StIdle) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = res_q;

  // result holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  // never accept while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");
  // divider is only started when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  // factor count never exceeds its store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fcnt_q) <= 32'(MAX_FACTORS))
    else $error("factor count overflow");

endmodule
